// ----- hw/rtl/assert_macros.svh -----
// assertion macros used by the checked integer alu top level
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold on every rising clock edge outside reset
`define ASSERT_CLK(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// implication checked in the next cycle
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ----- hw/rtl/cia_pkg.sv -----
// shared types and codes for the checked integer alu
`timescale 1ns / 1ps
`default_nettype none
package cia_pkg;
  localparam int unsigned KIND_BITS = 3;
  localparam logic [KIND_BITS-1:0] KIND_ADD = 3'd0;
  localparam logic [KIND_BITS-1:0] KIND_SUB = 3'd1;
  localparam logic [KIND_BITS-1:0] KIND_MUL = 3'd2;
  localparam logic [KIND_BITS-1:0] KIND_DIV = 3'd3;
  localparam logic [KIND_BITS-1:0] KIND_REM = 3'd4;
  localparam logic [KIND_BITS-1:0] KIND_NEG = 3'd5;

  // per-item control carried along the cell chain
  typedef struct packed {
    logic                 valid;
    logic [KIND_BITS-1:0] kind;
    logic                 neg_q;     // quotient or product is negative
    logic                 neg_r;     // remainder takes dividend sign
    logic                 early_err; // error known at entry
    logic                 early_ok;  // result known at entry
  } cia_ctl_t;
endpackage
`default_nettype wire

// ----- hw/rtl/cia_cell.sv -----
// one restoring-division and shift-add multiply step of the alu chain
`timescale 1ns / 1ps
`default_nettype none
module cia_cell #(
  parameter int unsigned W = 32
) (
  input  wire              clk,
  input  wire              en,
  input  wire cia_pkg::cia_ctl_t ctl_in,
  input  wire  [W-1:0]     rem_in,   // partial remainder
  input  wire  [W-1:0]     quo_in,   // dividend bits shifting out, quotient in
  input  wire  [W-1:0]     div_in,   // divisor magnitude
  input  wire  [2*W-1:0]   acc_in,   // product accumulator
  input  wire  [W-1:0]     mcand_in, // multiplicand magnitude
  input  wire  [W-1:0]     early_in, // early result
  output cia_pkg::cia_ctl_t ctl_out,
  output logic [W-1:0]     rem_out,
  output logic [W-1:0]     quo_out,
  output logic [W-1:0]     div_out,
  output logic [2*W-1:0]   acc_out,
  output logic [W-1:0]     mcand_out,
  output logic [W-1:0]     early_out
);
  import cia_pkg::*;

  logic [W:0]     trial;
  logic [W:0]     shifted;
  logic [2*W-1:0] acc_shift;

  always_comb begin
    shifted   = {rem_in, quo_in[W-1]};
    trial     = shifted - {1'b0, div_in};
    // multiply msb-first: acc = acc*2 + (bit ? mcand : 0), bit from quo
    acc_shift = {acc_in[2*W-2:0], 1'b0} +
                (quo_in[W-1] ? {{W{1'b0}}, mcand_in} : {(2*W){1'b0}});
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ctl_out   <= ctl_in;
      div_out   <= div_in;
      mcand_out <= mcand_in;
      early_out <= early_in;
      acc_out   <= acc_shift;
      if (!trial[W]) begin
        rem_out <= trial[W-1:0];
        quo_out <= {quo_in[W-2:0], 1'b1};
      end else begin
        rem_out <= shifted[W-1:0];
        quo_out <= {quo_in[W-2:0], 1'b0};
      end
    end
  end
endmodule
`default_nettype wire

// ----- hw/rtl/checked_integer_alu.sv -----
// top level of the checked integer alu
`timescale 1ns / 1ps
`default_nettype none
// Signed integer ALU with overflow checking. Each transfer on the input
// channel carries kind, operand_a and operand_b; exactly one transfer on the
// output channel returns value and error, in order. One new operation is
// taken every cycle unless the output stalls. For every kind, an entry
// stage takes magnitudes and settles add, subtract, negate and the special
// cases, then a chain of WORD_BITS identical cells runs one restoring-divide
// step and one shift-add multiply step each, and a final stage applies signs
// and the multiply range check. The whole chain advances only when the
// output register is free or being drained, so a stall holds every item.
// On any error, including an unused kind, value is zero.
`include "assert_macros.svh"
module checked_integer_alu #(
  parameter int unsigned WORD_BITS = 32
) (
  input  wire                          clk,
  input  wire                          rst,
  input  wire                          in_valid,
  output logic                         in_ready,
  input  wire  [cia_pkg::KIND_BITS-1:0] kind,
  input  wire  signed [WORD_BITS-1:0]  operand_a,
  input  wire  signed [WORD_BITS-1:0]  operand_b,
  output logic                         out_valid,
  input  wire                          out_ready,
  output logic signed [WORD_BITS-1:0]  value,
  output logic                         error
);
  import cia_pkg::*;

  localparam int unsigned W = WORD_BITS;

  // chain advances when the output register can take new data
  logic adv;
  assign adv      = !out_valid || out_ready;
  assign in_ready = adv;

  // entry decode
  logic [W-1:0] sign_min, all_ones, mag_a, mag_b, sum, diff, negv;
  logic         sa, sb;
  cia_ctl_t     ctl0;
  logic [W-1:0] early0;

  always_comb begin
    sign_min = {1'b1, {(W-1){1'b0}}};
    all_ones = {W{1'b1}};
    sa       = operand_a[W-1];
    sb       = operand_b[W-1];
    mag_a    = sa ? (~operand_a + 1'b1) : operand_a;
    mag_b    = sb ? (~operand_b + 1'b1) : operand_b;
    sum      = operand_a + operand_b;
    diff     = operand_a - operand_b;
    negv     = ~operand_a + 1'b1;
    ctl0.valid     = in_valid;
    ctl0.kind      = kind;
    ctl0.neg_q     = sa ^ sb;
    ctl0.neg_r     = sa;
    ctl0.early_err = 1'b0;
    ctl0.early_ok  = 1'b0;
    early0         = '0;
    unique case (kind)
      KIND_ADD: begin
        ctl0.early_ok  = 1'b1;
        ctl0.early_err = (sa == sb) && (sum[W-1] != sa);
        early0         = sum;
      end
      KIND_SUB: begin
        ctl0.early_ok  = 1'b1;
        ctl0.early_err = (sa != sb) && (diff[W-1] != sa);
        early0         = diff;
      end
      KIND_NEG: begin
        ctl0.early_ok  = 1'b1;
        ctl0.early_err = (operand_a == sign_min);
        early0         = negv;
      end
      KIND_MUL: ;
      KIND_DIV: ctl0.early_err = (operand_b == '0) ||
                                 ((operand_a == sign_min) && (operand_b == all_ones));
      KIND_REM: ctl0.early_err = (operand_b == '0);
      default: begin
        ctl0.early_ok  = 1'b1;
        ctl0.early_err = 1'b1;
      end
    endcase
  end

  // entry register feeds the cell chain
  cia_ctl_t     ctl_c   [0:W];
  logic [W-1:0] rem_c   [0:W];
  logic [W-1:0] quo_c   [0:W];
  logic [W-1:0] div_c   [0:W];
  logic [2*W-1:0] acc_c [0:W];
  logic [W-1:0] mc_c    [0:W];
  logic [W-1:0] ea_c    [0:W];

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl_c[0].valid <= 1'b0;
    end else if (adv) begin
      ctl_c[0].valid <= ctl0.valid;
    end
    if (adv) begin
      ctl_c[0].kind      <= ctl0.kind;
      ctl_c[0].neg_q     <= ctl0.neg_q;
      ctl_c[0].neg_r     <= ctl0.neg_r;
      ctl_c[0].early_err <= ctl0.early_err;
      ctl_c[0].early_ok  <= ctl0.early_ok;
      rem_c[0]           <= '0;
      quo_c[0]           <= mag_a;
      div_c[0]           <= mag_b;
      acc_c[0]           <= '0;
      mc_c[0]            <= mag_b;
      ea_c[0]            <= early0;
    end
  end

  // valid bits of the chain need reset; cells hold payload only
  logic [W:1] vld;
  cia_ctl_t   ctl_raw [1:W];

  for (genvar i = 0; i < W; i++) begin : g_cell
    cia_cell #(.W(W)) u_cell (
      .clk      (clk),
      .en       (adv),
      .ctl_in   (ctl_c[i]),
      .rem_in   (rem_c[i]),
      .quo_in   (quo_c[i]),
      .div_in   (div_c[i]),
      .acc_in   (acc_c[i]),
      .mcand_in (mc_c[i]),
      .early_in (ea_c[i]),
      .ctl_out  (ctl_raw[i+1]),
      .rem_out  (rem_c[i+1]),
      .quo_out  (quo_c[i+1]),
      .div_out  (div_c[i+1]),
      .acc_out  (acc_c[i+1]),
      .mcand_out(mc_c[i+1]),
      .early_out(ea_c[i+1])
    );
    always_ff @(posedge clk) begin
      if (rst) begin
        vld[i+1] <= 1'b0;
      end else if (adv) begin
        vld[i+1] <= ctl_c[i].valid;
      end
    end
    always_comb begin
      ctl_c[i+1]       = ctl_raw[i+1];
      ctl_c[i+1].valid = vld[i+1];
    end
  end

  // final stage: signs and range checks
  cia_ctl_t     cf;
  logic [W-1:0] quo_mag, rem_mag, prod_lo, res;
  logic [W-1:0] prod_hi;
  logic         err;

  always_comb begin
    cf      = ctl_c[W];
    quo_mag = quo_c[W];
    rem_mag = rem_c[W];
    prod_lo = acc_c[W][W-1:0];
    prod_hi = acc_c[W][2*W-1:W];
    err     = cf.early_err;
    res     = '0;
    if (cf.early_ok) begin
      res = ea_c[W];
    end else begin
      unique case (cf.kind)
        KIND_DIV: res = cf.neg_q ? (~quo_mag + 1'b1) : quo_mag;
        KIND_REM: res = cf.neg_r ? (~rem_mag + 1'b1) : rem_mag;
        KIND_MUL: begin
          // product fits if magnitude below 2^(W-1), or exactly 2^(W-1) when negative
          if (prod_hi != '0) begin
            err = 1'b1;
          end else if (prod_lo[W-1]) begin
            err = !(cf.neg_q && (prod_lo[W-2:0] == '0));
          end
          res = cf.neg_q ? (~prod_lo + 1'b1) : prod_lo;
        end
        default: res = '0;
      endcase
    end
    if (err) begin
      res = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= cf.valid;
    end
    if (adv) begin
      value <= res;
      error <= err;
    end
  end

  `ASSERT_CLK(a_err_zero, clk, rst, !(out_valid && error) || (value == '0),
              "error result carries nonzero value")
  `ASSERT_NEXT(a_stall_hold, clk, rst, out_valid && !out_ready, out_valid,
               "output dropped during stall")
  `ASSERT_CLK(a_ready_free, clk, rst, !out_valid || (in_ready == out_ready),
              "input ready not tied to output drain")
endmodule
`default_nettype wire

// ----- sim/tb_top.sv -----
// self-checking testbench for the checked integer alu
`timescale 1ns / 1ps
module tb_top;
  import cia_pkg::*;

  localparam int W = 32;
  localparam int LATENCY = W + 2;
  localparam int STALL_LIMIT = 20000;
  localparam int HOLD_LEN = 200;

  typedef struct {
    logic [W-1:0] value;
    logic         error;
  } alu_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [KIND_BITS-1:0] kind = KIND_ADD;
  logic signed [W-1:0] operand_a = '0;
  logic signed [W-1:0] operand_b = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [W-1:0] value;
  logic error;

  // results predicted for transfers not yet returned, oldest first
  alu_result_t pending_results[$];
  int fail_count = 0;
  int idle_cycles = 0;
  // percent chance per cycle that each side idles
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  // receiver hold-off: requested by the pressure test, counted by the receiver
  bit hold_req = 1'b0;
  bit hold_done = 1'b0;
  int hold_cycles = 0;

  checked_integer_alu #(.WORD_BITS(W)) u_top (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .kind(kind), .operand_a(operand_a), .operand_b(operand_b),
    .out_valid(out_valid), .out_ready(out_ready),
    .value(value), .error(error)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // exact checked arithmetic in 64-bit math; an error forces value to zero
  function automatic alu_result_t alu_predict(logic [KIND_BITS-1:0] op,
                                              logic signed [W-1:0] a,
                                              logic signed [W-1:0] b);
    alu_result_t r;
    longint sa;
    longint sb;
    longint full;
    sa = a;
    sb = b;
    r.error = 1'b0;
    full = 0;
    case (op)
      KIND_ADD: full = sa + sb;
      KIND_SUB: full = sa - sb;
      KIND_MUL: full = sa * sb;
      KIND_DIV: if (sb == 0) r.error = 1'b1; else full = sa / sb;
      KIND_REM: if (sb == 0) r.error = 1'b1; else full = sa % sb;
      KIND_NEG: full = -sa;
      default:  r.error = 1'b1;
    endcase
    // out of the word range covers every overflow incl. min / -1 and -min
    if (full > 64'sh7fffffff || full < -64'sh80000000) r.error = 1'b1;
    r.value = r.error ? '0 : full[W-1:0];
    return r;
  endfunction

  // send one operation and queue its prediction at the transfer
  task automatic send_op(logic [KIND_BITS-1:0] op, logic [W-1:0] a, logic [W-1:0] b);
    while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    kind <= op;
    operand_a <= a;
    operand_b <= b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    pending_results.push_back(alu_predict(op, a, b));
  endtask

  // operand biased toward the interesting corners
  function automatic logic [W-1:0] pick_operand();
    case ($urandom_range(9))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return 32'hffff_ffff;
      3: return '0;
      4: return $urandom_range(8) - 4;
      5: return $urandom_range(65535) - 32768;
      6: return 32'h1 << $urandom_range(31);
      default: return $urandom();
    endcase
  endfunction

  // receiver: random stalls, plus an explicit hold-off for the pressure test
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else if (hold_req && !hold_done) begin
      if (hold_cycles >= HOLD_LEN - 1) hold_done <= 1'b1;
      hold_cycles <= hold_cycles + 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= !(recv_idle_pct > 0 && $urandom_range(99) < recv_idle_pct);
    end
  end

  // result checker on each output transfer
  always @(posedge clk) begin
    alu_result_t exp_r;
    if (!rst && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result value=%h error=%b", $time, value, error);
        fail_count++;
      end else begin
        exp_r = pending_results.pop_front();
        if (value !== exp_r.value) begin
          $display("%0t: value mismatch expected %h actual %h", $time, exp_r.value, value);
          fail_count++;
        end
        if (error !== exp_r.error) begin
          $display("%0t: error mismatch expected %b actual %b", $time, exp_r.error, error);
          fail_count++;
        end
      end
    end
  end

  // watchdog on cycles with no transfer on either channel
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("** checked_integer_alu: FAILED **");
      $finish;
    end
  end

  // corners of each operation and every special case
  task automatic test_directed();
    send_op(KIND_ADD, 32'h7fff_ffff, 32'h1);         // positive overflow
    send_op(KIND_ADD, 32'h8000_0000, 32'hffff_ffff); // negative overflow
    send_op(KIND_ADD, 32'h8000_0000, 32'h7fff_ffff);
    send_op(KIND_SUB, 32'h8000_0000, 32'h1);
    send_op(KIND_SUB, 32'h7fff_ffff, 32'hffff_ffff);
    send_op(KIND_SUB, '0, 32'h8000_0000);
    send_op(KIND_MUL, 32'h8000_0000, 32'h1);         // min fits exactly
    send_op(KIND_MUL, 32'h8000_0000, 32'hffff_ffff); // overflow
    send_op(KIND_MUL, 32'h0001_0000, 32'h0000_8000);
    send_op(KIND_MUL, 32'hffff_0000, 32'h0000_8000);
    send_op(KIND_MUL, 32'h7fff_ffff, '0);
    send_op(KIND_DIV, 32'h1234_5678, '0);            // zero divisor
    send_op(KIND_DIV, 32'h8000_0000, 32'hffff_ffff); // min / -1
    send_op(KIND_DIV, 32'hffff_fff9, 32'h2);         // truncation toward zero
    send_op(KIND_REM, 32'hffff_fff9, 32'h2);         // sign of dividend
    send_op(KIND_REM, 32'h8000_0000, 32'hffff_ffff); // gives zero, no error
    send_op(KIND_REM, 32'h7, '0);
    send_op(KIND_NEG, 32'h8000_0000, 32'h5);         // negate min
    send_op(KIND_NEG, 32'h7fff_ffff, 32'hffff_ffff);
    send_op(3'd6, 32'h1, 32'h1);                     // unused kinds
    send_op(3'd7, 32'hffff_ffff, 32'hffff_ffff);
  endtask

  task automatic test_random(int count);
    for (int i = 0; i < count; i++) begin
      send_op($urandom_range(7) < 7 ? KIND_BITS'($urandom_range(5)) :
                                      KIND_BITS'($urandom_range(7, 6)),
              pick_operand(), pick_operand());
    end
  endtask

  // receiver holds off while the sender keeps offering, so the pipe backs up
  task automatic test_backpressure();
    hold_req = 1'b1;
    test_random(60);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    send_idle_pct = 21;
    recv_idle_pct = 85;
    test_directed();
    test_random(130);
    send_idle_pct = 85;
    recv_idle_pct = 21;
    test_random(130);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_backpressure();
    test_random(110);
    wait_drained();
    if (fail_count == 0) begin
      $display("** checked_integer_alu: PASSED **");
    end else begin
      $display("** checked_integer_alu: FAILED **");
    end
    $finish;
  end
endmodule
